[hdl/cda_pkg.sv]
// ----------------------------------------------------------------------------
// Calendar date adjust package
// Shared types, codes and calendar tables for the date adjust pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

    typedef enum logic [1:0] {
        OP_ADD_DAYS   = 2'd0,
        OP_ADD_MONTHS = 2'd1,
        OP_ADD_YEARS  = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DATE     = 2'd1,
        ERR_AMOUNT   = 2'd2,
        ERR_OVERFLOW = 2'd3
    } err_t;

    localparam logic [13:0] MAX_YEAR    = 14'd9999;
    localparam logic [3:0]  MONTH_JAN   = 4'd1;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_MAR   = 4'd3;
    localparam logic [3:0]  MONTH_DEC   = 4'd12;
    localparam logic [4:0]  LEAP_DAY    = 5'd29;
    localparam logic [4:0]  MAX_DAY_ADD = 5'd31;

    // Reciprocal of 100 scaled by 2^19; exact floor for values below 32768.
    localparam logic [12:0] DIV100_MULT = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    // Stage 1: input fields plus the century of the input year and of the
    // alternate year (year plus one, or year plus amount for a year add).
    typedef struct packed {
        op_t         op;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] amount;
        logic [14:0] year_alt;
        logic [7:0]  cent;
        logic [8:0]  cent_alt;
    } s1_t;

    // Stage 2: validated date with leap flags of both candidate years.
    typedef struct packed {
        op_t         op;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] amount;
        logic [14:0] year_alt;
        logic [1:0]  cent2;
        logic [6:0]  yy;
        logic [1:0]  cent_alt2;
        logic [6:0]  yy_alt;
        logic        leap;
        logic        leap_alt;
        logic        date_ok;
    } s2_t;

    // Stage 3: resulting date and what the weekday needs of its year.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [1:0]  cent2;
        logic [6:0]  yy;
        logic        leap;
        err_t        err;
    } s3_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            if (m == MONTH_FEB)
            begin
                len = leap ? 5'd29 : 5'd28;
            end
            else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
            begin
                len = 5'd30;
            end
            else
            begin
                len = 5'd31;
            end
            return len;
        end
    endfunction

    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] code;
        begin
            case (m)
                4'd1:    code = 3'd1;
                4'd2:    code = 3'd4;
                4'd3:    code = 3'd4;
                4'd4:    code = 3'd0;
                4'd5:    code = 3'd2;
                4'd6:    code = 3'd5;
                4'd7:    code = 3'd0;
                4'd8:    code = 3'd3;
                4'd9:    code = 3'd6;
                4'd10:   code = 3'd1;
                4'd11:   code = 3'd4;
                4'd12:   code = 3'd6;
                default: code = 3'd0;
            endcase
            return code;
        end
    endfunction

    function automatic logic [2:0] century_offset(input logic [1:0] c);
        logic [2:0] code;
        begin
            case (c)
                2'd0:    code = 3'd0;
                2'd1:    code = 3'd6;
                2'd2:    code = 3'd4;
                2'd3:    code = 3'd2;
                default: code = 3'd0;
            endcase
            return code;
        end
    endfunction

    // Leap rule from the year's low bits, its remainder by 100 and the low
    // bits of its century: divisible by 400 means remainder 0 and century % 4 == 0.
    function automatic logic leap_of(input logic [1:0] y2, input logic [6:0] yy,
                                     input logic [1:0] c2);
        begin
            return (y2 == 2'd0) && ((yy != 7'd0) || (c2 == 2'd0));
        end
    endfunction

endpackage

`default_nettype wire

[hdl/calendar_date_adjust_top.sv]
// ----------------------------------------------------------------------------
// Calendar date adjust top level
// Adds days, months or years to a Gregorian date and returns its weekday.
// ----------------------------------------------------------------------------
// Usage:
// An input transfer on the s_axis channel carries a date, an amount and the
// operation in tuser (add days, add months, add years). Each input transfer
// gives exactly one output transfer on the m_axis channel with the resulting
// date and weekday in tdata and the error code in tuser.
// The pipeline has four register stages: divide by 100, date check, add,
// weekday. The split, check, adjust and weekday registers lie in turn
// between the input transfer and the rise of m_axis_tvalid.
// Unless the pipeline is stalled, one transfer is accepted in every cycle;
// the throughput is one date per clock, set by the four pipeline registers
// each taking a new item per cycle. Reset clears all stage valid bits; the
// block then holds no items. When the receiver stalls, the output register
// holds its result and the stages behind it keep filling any empty slots;
// s_axis_tready falls only when every stage holds an item and m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_adjust_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,  // year_in, month_in, day_in, amount, zeros
    input  wire logic [1:0]   s_axis_tuser,  // operation
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // year_out, month_out, day_out, weekday, zeros
    output logic [1:0]        m_axis_tuser   // error_code
);

    logic          s1_valid;
    logic          s1_ready;
    cda_pkg::s1_t  s1_data;
    logic          s2_valid;
    logic          s2_ready;
    cda_pkg::s2_t  s2_data;
    logic          s3_valid;
    logic          s3_ready;
    cda_pkg::s3_t  s3_data;
    logic [13:0]   year_out;
    logic [3:0]    month_out;
    logic [4:0]    day_out;
    logic [2:0]    weekday;

    cda_split u_split (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_i  (s_axis_tvalid),
        .ready_o  (s_axis_tready),
        .op_i     (s_axis_tuser),
        .year_i   (s_axis_tdata[13:0]),
        .month_i  (s_axis_tdata[17:14]),
        .day_i    (s_axis_tdata[22:18]),
        .amount_i (s_axis_tdata[36:23]),
        .valid_o  (s1_valid),
        .ready_i  (s1_ready),
        .data_o   (s1_data)
    );

    cda_check u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (s1_valid),
        .ready_o (s1_ready),
        .data_i  (s1_data),
        .valid_o (s2_valid),
        .ready_i (s2_ready),
        .data_o  (s2_data)
    );

    cda_adjust u_adjust (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (s2_valid),
        .ready_o (s2_ready),
        .data_i  (s2_data),
        .valid_o (s3_valid),
        .ready_i (s3_ready),
        .data_o  (s3_data)
    );

    cda_weekday u_weekday (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_i      (s3_valid),
        .ready_o      (s3_ready),
        .data_i       (s3_data),
        .valid_o      (m_axis_tvalid),
        .ready_i      (m_axis_tready),
        .year_o       (year_out),
        .month_o      (month_out),
        .day_o        (day_out),
        .weekday_o    (weekday),
        .error_code_o (m_axis_tuser)
    );

    assign m_axis_tdata = {6'b0, weekday, day_out, month_out, year_out};

endmodule

`default_nettype wire

[hdl/cda_split.sv]
// ----------------------------------------------------------------------------
// Calendar date adjust, stage 1
// Registers the input transfer and divides both candidate years by 100.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_split (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         valid_i,
    output logic              ready_o,
    input  wire logic [1:0]   op_i,
    input  wire logic [13:0]  year_i,
    input  wire logic [3:0]   month_i,
    input  wire logic [4:0]   day_i,
    input  wire logic [13:0]  amount_i,
    output logic              valid_o,
    input  wire logic         ready_i,
    output cda_pkg::s1_t      data_o
);

    logic          valid_reg;
    cda_pkg::s1_t  data_reg;
    cda_pkg::s1_t  data_next;
    logic [14:0]   year_alt;
    logic [26:0]   prod_y;
    logic [27:0]   prod_alt;

    assign ready_o = !valid_reg || ready_i;
    assign valid_o = valid_reg;
    assign data_o  = data_reg;

    always_comb
    begin
        if (cda_pkg::op_t'(op_i) == cda_pkg::OP_ADD_YEARS)
        begin
            year_alt = {1'b0, year_i} + {1'b0, amount_i};
        end
        else
        begin
            year_alt = {1'b0, year_i} + 15'd1;
        end
        prod_y   = 27'(year_i) * 27'(cda_pkg::DIV100_MULT);
        prod_alt = 28'(year_alt) * 28'(cda_pkg::DIV100_MULT);

        data_next.op       = cda_pkg::op_t'(op_i);
        data_next.year     = year_i;
        data_next.month    = month_i;
        data_next.day      = day_i;
        data_next.amount   = amount_i;
        data_next.year_alt = year_alt;
        data_next.cent     = prod_y[cda_pkg::DIV100_SHIFT +: 8];
        data_next.cent_alt = prod_alt[cda_pkg::DIV100_SHIFT +: 9];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_o && valid_i)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[hdl/cda_check.sv]
// ----------------------------------------------------------------------------
// Calendar date adjust, stage 2
// Forms the year remainders and leap flags and validates the input date.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_check (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid_i,
    output logic               ready_o,
    input  wire cda_pkg::s1_t  data_i,
    output logic               valid_o,
    input  wire logic          ready_i,
    output cda_pkg::s2_t       data_o
);

    logic          valid_reg;
    cda_pkg::s2_t  data_reg;
    cda_pkg::s2_t  data_next;
    logic [13:0]   rem_y;
    logic [14:0]   rem_alt;
    logic          leap_y;
    logic          leap_alt;

    assign ready_o = !valid_reg || ready_i;
    assign valid_o = valid_reg;
    assign data_o  = data_reg;

    always_comb
    begin
        rem_y    = data_i.year - 14'(data_i.cent) * 14'd100;
        rem_alt  = data_i.year_alt - 15'(data_i.cent_alt) * 15'd100;
        leap_y   = cda_pkg::leap_of(data_i.year[1:0], rem_y[6:0], data_i.cent[1:0]);
        leap_alt = cda_pkg::leap_of(data_i.year_alt[1:0], rem_alt[6:0],
                                    data_i.cent_alt[1:0]);

        data_next.op        = data_i.op;
        data_next.year      = data_i.year;
        data_next.month     = data_i.month;
        data_next.day       = data_i.day;
        data_next.amount    = data_i.amount;
        data_next.year_alt  = data_i.year_alt;
        data_next.cent2     = data_i.cent[1:0];
        data_next.yy        = rem_y[6:0];
        data_next.cent_alt2 = data_i.cent_alt[1:0];
        data_next.yy_alt    = rem_alt[6:0];
        data_next.leap      = leap_y;
        data_next.leap_alt  = leap_alt;
        data_next.date_ok   = (data_i.year != 14'd0) && (data_i.year <= cda_pkg::MAX_YEAR)
                              && (data_i.month >= cda_pkg::MONTH_JAN)
                              && (data_i.month <= cda_pkg::MONTH_DEC)
                              && (data_i.day != 5'd0)
                              && (data_i.day <= cda_pkg::month_len(data_i.month, leap_y));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_o && valid_i)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[hdl/cda_adjust.sv]
// ----------------------------------------------------------------------------
// Calendar date adjust, stage 3
// Applies the day, month or year add and settles the error code.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_adjust (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid_i,
    output logic               ready_o,
    input  wire cda_pkg::s2_t  data_i,
    output logic               valid_o,
    input  wire logic          ready_i,
    output cda_pkg::s3_t       data_o
);

    logic          valid_reg;
    cda_pkg::s3_t  data_reg;
    cda_pkg::s3_t  data_next;

    logic [5:0]    nd0;
    logic [5:0]    nd1;
    logic [5:0]    nd2;
    logic [4:0]    len0;
    logic [4:0]    len1;
    logic [3:0]    m1;
    logic [3:0]    m2;
    logic          carry1;
    logic          carry2;
    logic [4:0]    msum;
    logic [3:0]    mwrap;
    logic          mcarry;
    logic [4:0]    mlen;
    logic [3:0]    new_month;
    logic [4:0]    new_day;
    logic          use_alt;
    cda_pkg::err_t err;

    assign ready_o = !valid_reg || ready_i;
    assign valid_o = valid_reg;
    assign data_o  = data_reg;

    always_comb
    begin
        // Day add: the sum is at most 62, so at most two month lengths come off.
        // Every month passed here lies in the input year, apart from a January
        // reached from December, which has 31 days in any year.
        nd0  = {1'b0, data_i.day} + {1'b0, data_i.amount[4:0]};
        len0 = cda_pkg::month_len(data_i.month, data_i.leap);
        if (nd0 > {1'b0, len0})
        begin
            nd1    = nd0 - {1'b0, len0};
            carry1 = (data_i.month == cda_pkg::MONTH_DEC);
            m1     = carry1 ? cda_pkg::MONTH_JAN : data_i.month + 4'd1;
        end
        else
        begin
            nd1    = nd0;
            carry1 = 1'b0;
            m1     = data_i.month;
        end
        len1 = cda_pkg::month_len(m1, data_i.leap);
        if (nd1 > {1'b0, len1})
        begin
            nd2    = nd1 - {1'b0, len1};
            carry2 = (m1 == cda_pkg::MONTH_DEC);
            m2     = carry2 ? cda_pkg::MONTH_JAN : m1 + 4'd1;
        end
        else
        begin
            nd2    = nd1;
            carry2 = 1'b0;
            m2     = m1;
        end

        // Month add: a wrap moves into the next year, whose leap flag is the
        // alternate one.
        msum   = {1'b0, data_i.month} + {1'b0, data_i.amount[3:0]};
        mcarry = (msum > {1'b0, cda_pkg::MONTH_DEC});
        mwrap  = mcarry ? 4'(msum - 5'd12) : msum[3:0];
        mlen   = cda_pkg::month_len(mwrap, mcarry ? data_i.leap_alt : data_i.leap);

        err       = cda_pkg::ERR_NONE;
        use_alt   = 1'b0;
        new_month = data_i.month;
        new_day   = data_i.day;

        if (!data_i.date_ok)
        begin
            err = cda_pkg::ERR_DATE;
        end
        else
        begin
            case (data_i.op)
                cda_pkg::OP_ADD_DAYS:
                begin
                    if (data_i.amount == 14'd0
                        || data_i.amount > 14'(cda_pkg::MAX_DAY_ADD))
                    begin
                        err = cda_pkg::ERR_AMOUNT;
                    end
                    else
                    begin
                        use_alt   = carry1 || carry2;
                        new_month = m2;
                        new_day   = nd2[4:0];
                    end
                end
                cda_pkg::OP_ADD_MONTHS:
                begin
                    if (data_i.amount == 14'd0
                        || data_i.amount > 14'(cda_pkg::MONTH_DEC))
                    begin
                        err = cda_pkg::ERR_AMOUNT;
                    end
                    else
                    begin
                        use_alt   = mcarry;
                        new_month = mwrap;
                        new_day   = (data_i.day > mlen) ? mlen : data_i.day;
                    end
                end
                cda_pkg::OP_ADD_YEARS:
                begin
                    use_alt = 1'b1;
                    if (data_i.month == cda_pkg::MONTH_FEB && data_i.day == cda_pkg::LEAP_DAY
                        && !data_i.leap_alt)
                    begin
                        new_month = cda_pkg::MONTH_MAR;
                        new_day   = 5'd1;
                    end
                end
                default:
                begin
                    err = cda_pkg::ERR_AMOUNT;
                end
            endcase
            if (err == cda_pkg::ERR_NONE && use_alt
                && data_i.year_alt > {1'b0, cda_pkg::MAX_YEAR})
            begin
                err = cda_pkg::ERR_OVERFLOW;
            end
        end

        // Any error echoes the input date.
        if (err == cda_pkg::ERR_NONE && use_alt)
        begin
            data_next.year  = data_i.year_alt[13:0];
            data_next.cent2 = data_i.cent_alt2;
            data_next.yy    = data_i.yy_alt;
            data_next.leap  = data_i.leap_alt;
        end
        else
        begin
            data_next.year  = data_i.year;
            data_next.cent2 = data_i.cent2;
            data_next.yy    = data_i.yy;
            data_next.leap  = data_i.leap;
        end
        data_next.month = (err == cda_pkg::ERR_NONE) ? new_month : data_i.month;
        data_next.day   = (err == cda_pkg::ERR_NONE) ? new_day : data_i.day;
        data_next.err   = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_o && valid_i)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[hdl/cda_weekday.sv]
// ----------------------------------------------------------------------------
// Calendar date adjust, stage 4
// Computes the weekday of the result and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_weekday (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid_i,
    output logic               ready_o,
    input  wire cda_pkg::s3_t  data_i,
    output logic               valid_o,
    input  wire logic          ready_i,
    output logic [13:0]        year_o,
    output logic [3:0]         month_o,
    output logic [4:0]         day_o,
    output logic [2:0]         weekday_o,
    output logic [1:0]         error_code_o
);

    logic          valid_reg;
    logic [13:0]   year_reg;
    logic [3:0]    month_reg;
    logic [4:0]    day_reg;
    logic [2:0]    weekday_reg;
    logic [1:0]    error_code_reg;
    logic [2:0]    weekday_next;

    logic [3:0]    mcode;
    logic [7:0]    sum;
    logic [16:0]   prod;
    logic [4:0]    quot;
    logic [7:0]    quot7;
    logic [7:0]    rem;

    assign ready_o      = !valid_reg || ready_i;
    assign valid_o      = valid_reg;
    assign year_o       = year_reg;
    assign month_o      = month_reg;
    assign day_o        = day_reg;
    assign weekday_o    = weekday_reg;
    assign error_code_o = error_code_reg;

    always_comb
    begin
        // January and February of a leap year step back one weekday.
        mcode = {1'b0, cda_pkg::month_offset(data_i.month)};
        if (data_i.month <= cda_pkg::MONTH_FEB && data_i.leap)
        begin
            mcode = mcode + 4'd6;
        end
        // The offset of 5 turns "0 is Saturday" into "0 is Monday".
        sum = 8'(data_i.day) + 8'(mcode)
              + 8'(cda_pkg::century_offset(data_i.cent2 + 2'd1))
              + 8'(data_i.yy) + 8'(data_i.yy[6:2]) + 8'd5;
        // Sum stays below 180; 293 / 2048 gives the exact quotient by 7 there.
        prod  = 17'(sum) * 17'd293;
        quot  = prod[15:11];
        quot7 = 8'({3'b0, quot} * 8'd7);
        rem   = sum - quot7;
        weekday_next = (data_i.err == cda_pkg::ERR_DATE) ? 3'd0 : rem[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_o && valid_i)
        begin
            year_reg       <= data_i.year;
            month_reg      <= data_i.month;
            day_reg        <= data_i.day;
            weekday_reg    <= weekday_next;
            error_code_reg <= data_i.err;
        end
    end

endmodule

`default_nettype wire

[hdl/cda_checker.sv]
// ----------------------------------------------------------------------------
// Calendar date adjust port checker
// Watches the top level's ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,
    input  wire logic [1:0]   s_axis_tuser,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [31:0]  m_axis_tdata,
    input  wire logic [1:0]   m_axis_tuser
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 40'd0
                     || s_axis_tuser != 2'd0 || 1'b1);

    // A stalled result holds until the transfer completes.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output result changed while stalled");

    // Every new result traces back to an accepted input transfer.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_xfer, 4))
        else $error("result without matching input transfer");

    // The weekday is always 0 to 6, and 0 for an invalid input date.
    a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[25:23] != 3'd7
        && (m_axis_tuser != cda_pkg::ERR_DATE || m_axis_tdata[25:23] == 3'd0))
        else $error("weekday out of range");

    // A successful result is a plausible date.
    a_date: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == cda_pkg::ERR_NONE |->
        m_axis_tdata[13:0] != 14'd0 && m_axis_tdata[13:0] <= cda_pkg::MAX_YEAR
        && m_axis_tdata[17:14] != 4'd0 && m_axis_tdata[17:14] <= cda_pkg::MONTH_DEC
        && m_axis_tdata[22:18] != 5'd0 && m_axis_tdata[31:26] == 6'd0)
        else $error("successful result is not a valid date");

endmodule

bind calendar_date_adjust_top cda_checker u_cda_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
